FILE: rtl/ftl_gc_pkg.sv
// Shared constants, datapath command codes and status struct for the FTL block.
package ftl_gc_pkg;

    localparam int BLOCK_COUNT     = 64;
    localparam int PAGES_PER_BLOCK = 64;
    localparam int LOGICAL_PAGES   = 3072;
    localparam int PHYS_PAGES      = BLOCK_COUNT * PAGES_PER_BLOCK;

    localparam int BLK_W  = $clog2(BLOCK_COUNT);
    localparam int PG_W   = $clog2(PAGES_PER_BLOCK);
    localparam int PPN_W  = 12;
    localparam int LBA_W  = 12;
    localparam int LMAP_W = PPN_W + 1;
    localparam int TOT_W  = 32;
    localparam int THR_W  = 7;
    localparam logic [THR_W-1:0] THR_RESET = 7'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_REFUSE,
        OP_MAP_RD,
        OP_VALID_RD,
        OP_INVAL,
        OP_ICNT_WR,
        OP_FIFO_RD,
        OP_POP,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_REL_RD,
        OP_REL_PROG,
        OP_REL_CLR,
        OP_GC_END,
        OP_HOST
    } dp_op_t;

    typedef struct packed {
        logic clr_done;
        logic refuse;
        logic mapped;
        logic old_valid;
        logic need_pop;
        logic gc_trigger;
        logic scan_last;
        logic found;
        logic rel_valid;
        logic pg_last;
    } dp_stat_t;

endpackage

FILE: rtl/page_mapped_ftl_greedy_gc.sv
// Page-mapped flash translation with greedy garbage collection.
// Input channel: in_valid / in_stall carry one host write request (lba).
// Output channel: out_valid / out_stall carry one result per request: ppn,
// gc_ran, victim_block, relocated_pages, host_writes, flash_writes, status.
// cfg_we / cfg_data write the garbage-collection free-block threshold.
// After reset a clearing pass erases the page map, the page valid marks and
// the invalid counts and loads the free-block list; in_stall stays high
// meanwhile.
// One request is handled at a time. An ordinary write's result waits on the
// chain of registered memory reads (map, page valid, invalid count). A refused
// request shows its result on the next cycle.
// Opening a new block adds the free-list read, the pop and the collection check.
// A collection adds a scan of the invalid count of every block, then for each
// victim page a read, a check, a program if the page is still valid and a
// clear, then a final step to finish.
// The result stays on the ports while out_stall is high; the next request
// is taken once the result has been delivered.
module page_mapped_ftl_greedy_gc (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ftl_gc_pkg::THR_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ftl_gc_pkg::LBA_W-1:0]   lba,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ftl_gc_pkg::PPN_W-1:0]   ppn,
    output logic                           gc_ran,
    output logic [ftl_gc_pkg::BLK_W-1:0]   victim_block,
    output logic [ftl_gc_pkg::PG_W:0]      relocated_pages,
    output logic [ftl_gc_pkg::TOT_W-1:0]   host_writes,
    output logic [ftl_gc_pkg::TOT_W-1:0]   flash_writes,
    output logic                           status
);
    import ftl_gc_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    ftl_gc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .op(op), .stat(stat));

    ftl_gc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .op(op), .stat(stat),
        .cfg_we(cfg_we), .cfg_data(cfg_data), .lba(lba),
        .ppn(ppn), .gc_ran(gc_ran), .victim_block(victim_block),
        .relocated_pages(relocated_pages), .host_writes(host_writes),
        .flash_writes(flash_writes), .status(status));

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after request accept");

    a_refuse_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (ppn == '0 && !gc_ran && relocated_pages == '0))
        else $error("refused request carries data");

    a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (relocated_pages <= (PG_W+1)'(PAGES_PER_BLOCK)))
        else $error("too many relocated pages");
`endif

endmodule

FILE: rtl/ftl_gc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ftl_gc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/ftl_gc_dp.sv
// Datapath: mapping, valid, owner, invalid-count and free-block memories plus counters.
module ftl_gc_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ftl_gc_pkg::dp_op_t             op,
    output ftl_gc_pkg::dp_stat_t           stat,
    input  logic                           cfg_we,
    input  logic [ftl_gc_pkg::THR_W-1:0]   cfg_data,
    input  logic [ftl_gc_pkg::LBA_W-1:0]   lba,
    output logic [ftl_gc_pkg::PPN_W-1:0]   ppn,
    output logic                           gc_ran,
    output logic [ftl_gc_pkg::BLK_W-1:0]   victim_block,
    output logic [ftl_gc_pkg::PG_W:0]      relocated_pages,
    output logic [ftl_gc_pkg::TOT_W-1:0]   host_writes,
    output logic [ftl_gc_pkg::TOT_W-1:0]   flash_writes,
    output logic                           status
);
    import ftl_gc_pkg::*;

    localparam int PA_W = $clog2(PHYS_PAGES);
    localparam int LA_W = $clog2(LOGICAL_PAGES);

    logic [PA_W-1:0]  clr_reg, clr_next;
    logic [LBA_W-1:0] lba_reg, lba_next;
    logic [THR_W-1:0] thr_reg, thr_next;
    logic [BLK_W-1:0] open_reg, open_next;
    logic [PG_W:0]    idx_reg, idx_next;
    logic [BLK_W-1:0] head_reg, head_next;
    logic [BLK_W:0]   fcnt_reg, fcnt_next;
    logic [BLK_W-1:0] scan_reg, scan_next;
    logic [BLK_W-1:0] best_reg, best_next;
    logic [PG_W:0]    bcnt_reg, bcnt_next;
    logic             found_reg, found_next;
    logic [PG_W-1:0]  pg_reg, pg_next;
    logic [PG_W:0]    moved_reg, moved_next;
    logic [PPN_W-1:0] ppn_reg, ppn_next;
    logic             ran_reg, ran_next;
    logic             status_reg, status_next;
    logic [TOT_W-1:0] host_reg, host_next;
    logic [TOT_W-1:0] flash_reg, flash_next;

    logic              lm_we, pv_we, pv_wd, pv_re, po_we, ic_we, ic_re, ff_we, ff_re;
    logic [LA_W-1:0]   lm_waddr;
    logic [LMAP_W-1:0] lm_wdata, lm_rdata;
    logic [PA_W-1:0]   pv_waddr, pv_raddr;
    logic              pv_rdata;
    logic [PA_W-1:0]   po_waddr;
    logic [LBA_W-1:0]  po_wdata, po_rdata;
    logic [BLK_W-1:0]  ic_waddr, ic_raddr, ff_waddr, ff_wdata, ff_rdata;
    logic [PG_W:0]     ic_wdata, ic_rdata;

    logic [PPN_W-1:0]  new_ppn, host_ppn, vic_ppn;
    logic [PG_W:0]     idx_cl;

    assign new_ppn  = {open_reg, idx_reg[PG_W-1:0]};
    assign idx_cl   = (idx_reg >= (PG_W+1)'(PAGES_PER_BLOCK)) ?
                      (PG_W+1)'(PAGES_PER_BLOCK - 1) : idx_reg;
    assign host_ppn = {open_reg, idx_cl[PG_W-1:0]};
    assign vic_ppn  = {best_reg, pg_reg};

    ftl_gc_ram #(.WIDTH(LMAP_W), .DEPTH(LOGICAL_PAGES)) u_lmap (
        .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
        .re(op == OP_MAP_RD), .raddr(lba_reg[LA_W-1:0]), .rdata(lm_rdata));

    ftl_gc_ram #(.WIDTH(1), .DEPTH(PHYS_PAGES)) u_pvalid (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wd),
        .re(pv_re), .raddr(pv_raddr), .rdata(pv_rdata));

    ftl_gc_ram #(.WIDTH(LBA_W), .DEPTH(PHYS_PAGES)) u_powner (
        .clk(clk), .we(po_we), .waddr(po_waddr), .wdata(po_wdata),
        .re(op == OP_REL_RD), .raddr(vic_ppn), .rdata(po_rdata));

    ftl_gc_ram #(.WIDTH(PG_W+1), .DEPTH(BLOCK_COUNT)) u_icnt (
        .clk(clk), .we(ic_we), .waddr(ic_waddr), .wdata(ic_wdata),
        .re(ic_re), .raddr(ic_raddr), .rdata(ic_rdata));

    ftl_gc_ram #(.WIDTH(BLK_W), .DEPTH(BLOCK_COUNT)) u_fifo (
        .clk(clk), .we(ff_we), .waddr(ff_waddr), .wdata(ff_wdata),
        .re(ff_re), .raddr(head_reg), .rdata(ff_rdata));

    always_comb
    begin
        lm_we = 1'b0; lm_waddr = lba_reg[LA_W-1:0]; lm_wdata = {1'b1, host_ppn};
        pv_we = 1'b0; pv_waddr = host_ppn; pv_wd = 1'b0;
        pv_re = 1'b0; pv_raddr = vic_ppn;
        po_we = 1'b0; po_waddr = host_ppn; po_wdata = lba_reg;
        ic_we = 1'b0; ic_waddr = lm_rdata[PPN_W-1 -: BLK_W]; ic_wdata = ic_rdata;
        ic_re = 1'b0; ic_raddr = lm_rdata[PPN_W-1 -: BLK_W];
        ff_we = 1'b0; ff_waddr = head_reg + fcnt_reg[BLK_W-1:0]; ff_wdata = best_reg;
        ff_re = 1'b0;

        clr_next = clr_reg; lba_next = lba_reg; thr_next = thr_reg;
        open_next = open_reg; idx_next = idx_reg; head_next = head_reg;
        fcnt_next = fcnt_reg; scan_next = scan_reg; best_next = best_reg;
        bcnt_next = bcnt_reg; found_next = found_reg; pg_next = pg_reg;
        moved_next = moved_reg; ppn_next = ppn_reg; ran_next = ran_reg;
        status_next = status_reg; host_next = host_reg; flash_next = flash_reg;

        if (cfg_we)
        begin
            thr_next = cfg_data;
        end

        case (op)
            OP_CLEAR:
            begin
                pv_we = 1'b1; pv_waddr = clr_reg;
                if (clr_reg < PA_W'(LOGICAL_PAGES))
                begin
                    lm_we = 1'b1; lm_waddr = clr_reg[LA_W-1:0]; lm_wdata = '0;
                end
                if (clr_reg < PA_W'(BLOCK_COUNT))
                begin
                    ic_we = 1'b1; ic_waddr = clr_reg[BLK_W-1:0]; ic_wdata = '0;
                    ff_we = 1'b1; ff_waddr = clr_reg[BLK_W-1:0];
                    ff_wdata = clr_reg[BLK_W-1:0];
                end
                clr_next = clr_reg + 1'b1;
            end
            OP_LOAD, OP_REFUSE:
            begin
                lba_next = lba; ppn_next = '0; ran_next = 1'b0;
                moved_next = '0; status_next = (op == OP_REFUSE);
            end
            OP_VALID_RD:
            begin
                pv_re = 1'b1; pv_raddr = lm_rdata[PPN_W-1:0];
            end
            OP_INVAL:
            begin
                pv_we = 1'b1; pv_waddr = lm_rdata[PPN_W-1:0];
                ic_re = 1'b1;
            end
            OP_ICNT_WR:
            begin
                if (ic_rdata < (PG_W+1)'(PAGES_PER_BLOCK))
                begin
                    ic_we = 1'b1; ic_wdata = ic_rdata + 1'b1;
                end
            end
            OP_FIFO_RD: ff_re = 1'b1;
            OP_POP:
            begin
                open_next = ff_rdata; head_next = head_reg + 1'b1;
                fcnt_next = fcnt_reg - 1'b1; idx_next = '0;
            end
            OP_SCAN_INIT:
            begin
                scan_next = '0; best_next = '0; bcnt_next = '0;
                found_next = 1'b0; pg_next = '0;
            end
            OP_SCAN_RD:
            begin
                ic_re = 1'b1; ic_raddr = scan_reg;
            end
            OP_SCAN_CMP:
            begin
                if (scan_reg != open_reg && ic_rdata > bcnt_reg)
                begin
                    best_next = scan_reg; bcnt_next = ic_rdata; found_next = 1'b1;
                end
                scan_next = scan_reg + 1'b1;
            end
            OP_REL_RD: pv_re = 1'b1;
            OP_REL_PROG:
            begin
                pv_we = 1'b1; pv_waddr = new_ppn; pv_wd = 1'b1;
                po_we = 1'b1; po_waddr = new_ppn; po_wdata = po_rdata;
                lm_we = 1'b1; lm_waddr = po_rdata[LA_W-1:0]; lm_wdata = {1'b1, new_ppn};
                flash_next = (flash_reg == '1) ? flash_reg : flash_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                moved_next = moved_reg + 1'b1;
            end
            OP_REL_CLR:
            begin
                pv_we = 1'b1; pv_waddr = vic_ppn;
                pg_next = pg_reg + 1'b1;
            end
            OP_GC_END:
            begin
                ic_we = 1'b1; ic_waddr = best_reg; ic_wdata = '0;
                if (fcnt_reg < (BLK_W+1)'(BLOCK_COUNT))
                begin
                    ff_we = 1'b1; fcnt_next = fcnt_reg + 1'b1;
                end
                ran_next = 1'b1;
            end
            OP_HOST:
            begin
                pv_we = 1'b1; pv_wd = 1'b1;
                po_we = 1'b1;
                lm_we = 1'b1;
                flash_next = (flash_reg == '1) ? flash_reg : flash_reg + 1'b1;
                host_next = (host_reg == '1) ? host_reg : host_reg + 1'b1;
                ppn_next = host_ppn;
                idx_next = idx_cl + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0; lba_reg <= '0; thr_reg <= THR_RESET;
            open_reg <= '0; idx_reg <= (PG_W+1)'(PAGES_PER_BLOCK);
            head_reg <= '0; fcnt_reg <= (BLK_W+1)'(BLOCK_COUNT);
            scan_reg <= '0; best_reg <= '0; bcnt_reg <= '0; found_reg <= 1'b0;
            pg_reg <= '0; moved_reg <= '0; ppn_reg <= '0; ran_reg <= 1'b0;
            status_reg <= 1'b0; host_reg <= '0; flash_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next; lba_reg <= lba_next; thr_reg <= thr_next;
            open_reg <= open_next; idx_reg <= idx_next;
            head_reg <= head_next; fcnt_reg <= fcnt_next;
            scan_reg <= scan_next; best_reg <= best_next; bcnt_reg <= bcnt_next;
            found_reg <= found_next; pg_reg <= pg_next; moved_reg <= moved_next;
            ppn_reg <= ppn_next; ran_reg <= ran_next; status_reg <= status_next;
            host_reg <= host_next; flash_reg <= flash_next;
        end
    end

    always_comb
    begin
        stat.clr_done   = (clr_reg == PA_W'(PHYS_PAGES - 1));
        stat.refuse     = (lba >= LBA_W'(LOGICAL_PAGES)) ||
                          (idx_reg >= (PG_W+1)'(PAGES_PER_BLOCK) && fcnt_reg == '0);
        stat.mapped     = lm_rdata[LMAP_W-1];
        stat.old_valid  = pv_rdata;
        stat.need_pop   = (idx_reg >= (PG_W+1)'(PAGES_PER_BLOCK));
        stat.gc_trigger = ({1'b0, fcnt_reg} <= (THR_W+1)'(thr_reg));
        stat.scan_last  = (scan_reg == BLK_W'(BLOCK_COUNT - 1));
        stat.found      = found_reg;
        stat.rel_valid  = pv_rdata && (idx_reg < (PG_W+1)'(PAGES_PER_BLOCK));
        stat.pg_last    = (pg_reg == PG_W'(PAGES_PER_BLOCK - 1));
    end

    assign ppn             = ppn_reg;
    assign gc_ran          = ran_reg;
    assign victim_block    = ran_reg ? best_reg : '0;
    assign relocated_pages = moved_reg;
    assign host_writes     = host_reg;
    assign flash_writes    = flash_reg;
    assign status          = status_reg;

endmodule

FILE: rtl/ftl_gc_ctrl.sv
// Controller: sequences one host write, the block pop and the collection burst.
module ftl_gc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ftl_gc_pkg::dp_op_t   op,
    input  ftl_gc_pkg::dp_stat_t stat
);
    import ftl_gc_pkg::*;

    typedef enum logic [19:0] {
        S_CLR      = 20'h00001,
        S_IDLE     = 20'h00002,
        S_MAP_RD   = 20'h00004,
        S_MAP_CHK  = 20'h00008,
        S_VAL_CHK  = 20'h00010,
        S_INVAL    = 20'h00020,
        S_ICNT_WR  = 20'h00040,
        S_FIFO_RD  = 20'h00080,
        S_POP      = 20'h00100,
        S_GC_CHK   = 20'h00200,
        S_SCAN_RD  = 20'h00400,
        S_SCAN_CMP = 20'h00800,
        S_SCAN_END = 20'h01000,
        S_REL_RD   = 20'h02000,
        S_REL_CHK  = 20'h04000,
        S_REL_PROG = 20'h08000,
        S_REL_CLR  = 20'h10000,
        S_GC_END   = 20'h20000,
        S_HOST     = 20'h40000,
        S_OUT      = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    state_t after_map;

    // after the old mapping is handled, open a block if the current one is full
    assign after_map = stat.need_pop ? S_FIFO_RD : S_HOST;

    always_comb
    begin
        state_next = state_reg;
        op = OP_NONE;
        case (state_reg)
            S_CLR:
            begin
                op = OP_CLEAR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = stat.refuse ? OP_REFUSE : OP_LOAD;
                    state_next = stat.refuse ? S_OUT : S_MAP_RD;
                end
            end
            S_MAP_RD:
            begin
                op = OP_MAP_RD;
                state_next = S_MAP_CHK;
            end
            S_MAP_CHK:
            begin
                if (stat.mapped)
                begin
                    op = OP_VALID_RD;
                    state_next = S_VAL_CHK;
                end
                else
                begin
                    state_next = after_map;
                end
            end
            S_VAL_CHK:  state_next = stat.old_valid ? S_INVAL : after_map;
            S_INVAL:
            begin
                op = OP_INVAL;
                state_next = S_ICNT_WR;
            end
            S_ICNT_WR:
            begin
                op = OP_ICNT_WR;
                state_next = after_map;
            end
            S_FIFO_RD:
            begin
                op = OP_FIFO_RD;
                state_next = S_POP;
            end
            S_POP:
            begin
                op = OP_POP;
                state_next = S_GC_CHK;
            end
            S_GC_CHK:
            begin
                if (stat.gc_trigger)
                begin
                    op = OP_SCAN_INIT;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_HOST;
                end
            end
            S_SCAN_RD:
            begin
                op = OP_SCAN_RD;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                op = OP_SCAN_CMP;
                state_next = stat.scan_last ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END: state_next = stat.found ? S_REL_RD : S_HOST;
            S_REL_RD:
            begin
                op = OP_REL_RD;
                state_next = S_REL_CHK;
            end
            S_REL_CHK:  state_next = stat.rel_valid ? S_REL_PROG : S_REL_CLR;
            S_REL_PROG:
            begin
                op = OP_REL_PROG;
                state_next = S_REL_CLR;
            end
            S_REL_CLR:
            begin
                op = OP_REL_CLR;
                state_next = stat.pg_last ? S_GC_END : S_REL_RD;
            end
            S_GC_END:
            begin
                op = OP_GC_END;
                state_next = S_HOST;
            end
            S_HOST:
            begin
                op = OP_HOST;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

FILE: tb/page_mapped_ftl_greedy_gc_tb.sv
// Self-checking testbench for the page-mapped FTL with greedy garbage collection.
module page_mapped_ftl_greedy_gc_tb;
    import ftl_gc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;
    localparam int   IDLE_WAIT  = 400;

    typedef struct packed {
        logic [PPN_W-1:0]  ppn;
        logic              gc_ran;
        logic [BLK_W-1:0]  victim;
        logic [PG_W:0]     moved;
        logic [TOT_W-1:0]  host_cnt;
        logic [TOT_W-1:0]  flash_cnt;
        logic              status;
    } write_result_t;

    typedef struct {
        logic [LBA_W-1:0] lba;
        bit               typed;
        logic [PPN_W-1:0] ppn;
        logic             status;
    } host_write_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [LBA_W-1:0] lba;
    logic             out_valid;
    logic             out_stall;
    logic [PPN_W-1:0] ppn;
    logic             gc_ran;
    logic [BLK_W-1:0] victim_block;
    logic [PG_W:0]    relocated_pages;
    logic [TOT_W-1:0] host_writes;
    logic [TOT_W-1:0] flash_writes;
    logic             status;

    page_mapped_ftl_greedy_gc DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .lba(lba),
        .out_valid(out_valid), .out_stall(out_stall), .ppn(ppn), .gc_ran(gc_ran),
        .victim_block(victim_block), .relocated_pages(relocated_pages),
        .host_writes(host_writes), .flash_writes(flash_writes), .status(status)
    );

    // mirror of the translation state
    logic [LMAP_W-1:0] lmap [LOGICAL_PAGES];
    bit                pg_valid [PHYS_PAGES];
    logic [LBA_W-1:0]  pg_owner [PHYS_PAGES];
    int                inval_cnt [BLOCK_COUNT];
    int                free_fifo [BLOCK_COUNT];
    int                fifo_head, free_cnt, open_blk, open_pg;
    int                gc_thr;
    logic [TOT_W-1:0]  host_total, flash_total;

    write_result_t     expected_q[$];
    int                accepted;
    bit                failed;
    bit                hold_off;

    // current request annotation, stable while in_valid is high
    bit                cur_typed;
    logic [PPN_W-1:0]  cur_ppn;
    logic              cur_status;

    host_write_t       directed [$];

    function automatic logic [TOT_W-1:0] sat_inc(logic [TOT_W-1:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    task automatic program_page(int p, logic [LBA_W-1:0] l);
        pg_valid[p] = 1'b1;
        pg_owner[p] = l;
        lmap[l]     = {1'b1, PPN_W'(p)};
        flash_total = sat_inc(flash_total);
    endtask

    task automatic collect(inout write_result_t r);
        int best, best_cnt, base, n;
        best = 0;
        best_cnt = 0;
        n = 0;
        for (int b = 0; b < BLOCK_COUNT; b++)
            if (b != open_blk && inval_cnt[b] > best_cnt)
            begin
                best_cnt = inval_cnt[b];
                best = b;
            end
        if (best_cnt == 0)
            return;
        base = best * PAGES_PER_BLOCK;
        for (int i = 0; i < PAGES_PER_BLOCK; i++)
            if (pg_valid[base + i] && open_pg < PAGES_PER_BLOCK)
            begin
                program_page(open_blk * PAGES_PER_BLOCK + open_pg, pg_owner[base + i]);
                open_pg++;
                n++;
            end
        for (int i = 0; i < PAGES_PER_BLOCK; i++)
            pg_valid[base + i] = 1'b0;
        inval_cnt[best] = 0;
        if (free_cnt < BLOCK_COUNT)
        begin
            free_fifo[(fifo_head + free_cnt) % BLOCK_COUNT] = best;
            free_cnt++;
        end
        r.gc_ran = 1'b1;
        r.victim = BLK_W'(best);
        r.moved  = (PG_W + 1)'(n);
    endtask

    task automatic translate_write(logic [LBA_W-1:0] a, output write_result_t r);
        int old, p;
        r = '0;
        if (a >= LOGICAL_PAGES || (open_pg >= PAGES_PER_BLOCK && free_cnt == 0))
            r.status = ST_REFUSED;
        else
        begin
            if (lmap[a][LMAP_W-1])
            begin
                old = lmap[a][PPN_W-1:0];
                if (pg_valid[old])
                begin
                    pg_valid[old] = 1'b0;
                    if (inval_cnt[old / PAGES_PER_BLOCK] < PAGES_PER_BLOCK)
                        inval_cnt[old / PAGES_PER_BLOCK]++;
                end
            end
            if (open_pg >= PAGES_PER_BLOCK)
            begin
                open_blk = free_fifo[fifo_head];
                fifo_head = (fifo_head + 1) % BLOCK_COUNT;
                free_cnt--;
                open_pg = 0;
                if (free_cnt <= gc_thr)
                    collect(r);
            end
            if (open_pg >= PAGES_PER_BLOCK)
                open_pg = PAGES_PER_BLOCK - 1;
            p = open_blk * PAGES_PER_BLOCK + open_pg;
            r.ppn = PPN_W'(p);
            program_page(p, a);
            open_pg++;
            host_total = sat_inc(host_total);
            r.status = ST_OK;
        end
        r.host_cnt  = host_total;
        r.flash_cnt = flash_total;
    endtask

    function automatic void check_field(string name, longint unsigned e, longint unsigned a);
        if (e != a)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, e, a);
            failed = 1'b1;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("page_mapped_ftl_greedy_gc regression: fail");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < LOGICAL_PAGES; i++)
            lmap[i] = '0;
        for (int i = 0; i < PHYS_PAGES; i++)
            pg_valid[i] = 1'b0;
        for (int b = 0; b < BLOCK_COUNT; b++)
        begin
            inval_cnt[b] = 0;
            free_fifo[b] = b;
        end
        fifo_head = 0;
        free_cnt = BLOCK_COUNT;
        open_blk = 0;
        open_pg = PAGES_PER_BLOCK;
        gc_thr = THR_RESET;
        host_total = '0;
        flash_total = '0;
        accepted = 0;
        failed = 1'b0;
    end

    // scoreboard: predict on request accept, compare on result accept
    always @(posedge clk)
    begin
        write_result_t r, e;
        if (rst_n)
        begin
            if (cfg_we)
                gc_thr = cfg_data;
            if (in_valid && !in_stall)
            begin
                translate_write(lba, r);
                if (cur_typed)
                begin
                    r.ppn = cur_ppn;
                    r.status = cur_status;
                end
                expected_q.push_back(r);
                accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result ppn %0d", $realtime, ppn);
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("ppn", e.ppn, ppn);
                    check_field("gc_ran", e.gc_ran, gc_ran);
                    check_field("victim_block", e.victim, victim_block);
                    check_field("relocated_pages", e.moved, relocated_pages);
                    check_field("host_writes", e.host_cnt, host_writes);
                    check_field("flash_writes", e.flash_cnt, flash_writes);
                    check_field("status", e.status, status);
                end
            end
        end
    end

    // receiver: stall pattern of its own, plus the long hold-off
    initial
    begin
        int mode;
        out_stall = 1'b0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 3);
            if (hold_off)
                out_stall <= 1'b1;
            else
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (accepted >= 120);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
    end

    int burst_left;

    task automatic send_write(host_write_t w);
        int target;
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        target = accepted + 1;
        in_valid   <= 1'b1;
        lba        <= w.lba;
        cur_typed  <= w.typed;
        cur_ppn    <= w.ppn;
        cur_status <= w.status;
        do
            @(negedge clk);
        while (accepted < target);
    endtask

    function automatic host_write_t rand_write(int span);
        host_write_t w;
        int k;
        w.typed = 1'b0;
        w.ppn = '0;
        w.status = ST_OK;
        k = $urandom_range(0, 99);
        if (k < 70)
            w.lba = LBA_W'($urandom_range(0, span));
        else if (k < 85)
            w.lba = LBA_W'($urandom_range(0, LOGICAL_PAGES - 1));
        else
            w.lba = LBA_W'($urandom());
        return w;
    endfunction

    // wait for every result, let the block settle, then write the threshold
    task automatic set_threshold(logic [THR_W-1:0] v);
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_phase(int count, int span);
        for (int i = 0; i < count; i++)
            send_write(rand_write(span));
    endtask

    initial
    begin
        host_write_t w;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        lba        = '0;
        cur_typed  = 1'b0;
        cur_ppn    = '0;
        cur_status = ST_OK;
        burst_left = 0;

        // lba, typed, ppn, status
        directed.push_back('{12'd0,    1'b1, 12'd0, ST_OK});
        directed.push_back('{12'd3071, 1'b1, 12'd1, ST_OK});
        directed.push_back('{12'd4095, 1'b1, 12'd0, ST_REFUSED});
        directed.push_back('{12'd3072, 1'b1, 12'd0, ST_REFUSED});
        directed.push_back('{12'd0,    1'b1, 12'd2, ST_OK});
        directed.push_back('{12'd2730, 1'b1, 12'd3, ST_OK});
        directed.push_back('{12'd1365, 1'b1, 12'd4, ST_OK});
        for (int i = 0; i < 14; i++)
            directed.push_back('{LBA_W'(i % 4), 1'b0, 12'd0, ST_OK});

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_write(directed[i]);

        // collect on every block open
        set_threshold(7'd64);
        random_phase(80, 40);
        w = '{12'd4095, 1'b0, 12'd0, ST_OK};
        send_write(w);
        random_phase(80, 100);

        set_threshold(7'd0);
        random_phase(90, 2000);

        set_threshold(7'($urandom_range(1, 63)));
        random_phase(130, 200);

        set_threshold(7'd64);
        random_phase(110, 60);

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
        if (!failed && expected_q.size() == 0)
            $display("page_mapped_ftl_greedy_gc regression: pass");
        else
            $display("page_mapped_ftl_greedy_gc regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ftl_gc_pkg.sv
rtl/ftl_gc_ram.sv
rtl/ftl_gc_dp.sv
rtl/ftl_gc_ctrl.sv
rtl/page_mapped_ftl_greedy_gc.sv
tb/page_mapped_ftl_greedy_gc_tb.sv
